>>> rtl/column_sum_byte_digest_macros.svh
// ---------------------------------------------------------------------------
// column_sum_byte_digest assertion macros
// Shared property wrappers; they expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef COLUMN_SUM_BYTE_DIGEST_MACROS_SVH
`define COLUMN_SUM_BYTE_DIGEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CSBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CSBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/csbd_pkg.sv
// ---------------------------------------------------------------------------
// csbd_pkg
// Shared constants and types of the column-sum byte digest.
// ---------------------------------------------------------------------------
package csbd_pkg;

  // Row width register
  localparam int CFG_W           = 7;
  localparam int MIN_WIDTH       = 16;
  localparam int ROW_WIDTH_RST   = 16;

  // Default column store depth
  localparam int DEF_MAX_COLUMNS = 64;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH     = 4;

  // Word as it travels from the front to the back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

endpackage

>>> rtl/csbd_ifs.sv
// ---------------------------------------------------------------------------
// csbd channel interfaces
// Valid/ready channels for message words in and digest words out.
// ---------------------------------------------------------------------------
interface csbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface csbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       digest_last;

  modport source (output valid, output digest_byte, output digest_last, input ready);
  modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

>>> rtl/csbd_ram.sv
// ---------------------------------------------------------------------------
// csbd_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module csbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/csbd_front.sv
// ---------------------------------------------------------------------------
// csbd_front
// Accepts message words, drops words with neither byte nor end, and queues
// the rest for the back end.
// ---------------------------------------------------------------------------
module csbd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  csbd_in_if.sink              in_ch,
  output csbd_pkg::item_t      item,
  output logic                 item_vld,
  input  logic                 item_pop
);

  localparam int DEPTH = csbd_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  csbd_pkg::item_t q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push;
  logic            pop;
  csbd_pkg::item_t in_item;

  // Classify: only words that add a byte or close the message go on
  assign in_ch.ready = (cnt_r != CNTW'(DEPTH));
  assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
  assign pop  = item_pop && item_vld;

  assign in_item.data_byte      = in_ch.data_byte;
  assign in_item.has_byte       = in_ch.has_byte;
  assign in_item.end_of_message = in_ch.end_of_message;

  assign item_vld = (cnt_r != '0);
  assign item     = q_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + PW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + PW'(1));
    end
    if (push && !pop) begin
      cnt_nxt = CNTW'(cnt_r + CNTW'(1));
    end else if (pop && !push) begin
      cnt_nxt = CNTW'(cnt_r - CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> rtl/csbd_back.sv
// ---------------------------------------------------------------------------
// csbd_back
// Column accumulate, end-of-row padding and digest fold over the column RAM.
// ---------------------------------------------------------------------------
`include "column_sum_byte_digest_macros.svh"

module csbd_back #(
  parameter int MAX_COLUMNS = csbd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [csbd_pkg::CFG_W-1:0] row_width,
  input  csbd_pkg::item_t            item,
  input  logic                       item_vld,
  output logic                       item_pop,
  csbd_out_if.source                 out_ch
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int CW = (AW + 1 > csbd_pkg::CFG_W) ? AW + 1 : csbd_pkg::CFG_W;

  typedef enum logic [2:0] {S_RUN, S_PAD, S_FOLD, S_SUM, S_OUT} state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [MAX_COLUMNS-1:0] col_vld_r;
  logic             vld_q_r;
  logic             fold_rd_r;
  logic             b_vld_r;
  logic [AW-1:0]    b_addr_r;
  logic [7:0]       b_add_r;
  logic             out_vld_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [CW-1:0]    rw_ext;
  logic [CW-1:0]    n_clamp;
  logic [CW-1:0]    n_w;
  logic [7:0]       pad_val;
  logic [AW-1:0]    pos_eff;
  logic [CW-1:0]    pos_inc;
  logic [AW-1:0]    pos_wrap;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       ram_q;
  logic [7:0]       rd_q;
  logic             rmw_issue;
  logic [7:0]       rmw_add;
  logic             fold_rd;
  logic             out_load;
  logic             clr_all;
  logic             done;

  // Effective row width: clamp, then round down to a multiple of four
  always_comb begin
    rw_ext = CW'(row_width);
    if (rw_ext < CW'(csbd_pkg::MIN_WIDTH)) begin
      n_clamp = CW'(csbd_pkg::MIN_WIDTH);
    end else if (rw_ext > CW'(MAX_COLUMNS)) begin
      n_clamp = CW'(MAX_COLUMNS);
    end else begin
      n_clamp = rw_ext;
    end
    n_w = n_clamp & ~CW'(3);
  end

  assign pad_val = 8'(n_w);

  // Column position: restart the row if the width shrank under it
  assign pos_eff  = (CW'(pos_r) >= n_w) ? '0 : pos_r;
  assign pos_inc  = CW'(pos_eff) + CW'(1);
  assign pos_wrap = (pos_inc >= n_w) ? '0 : pos_inc[AW-1:0];

  // Entries not written since the last clear read as zero
  assign rd_q = vld_q_r ? ram_q : 8'd0;
  assign done = (j_r == n_w);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    j_nxt     = j_r;
    acc_nxt   = acc_r;
    item_pop  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = pos_eff;
    rmw_issue = 1'b0;
    rmw_add   = item.data_byte;
    fold_rd   = 1'b0;
    out_load  = 1'b0;
    clr_all   = 1'b0;

    if (fold_rd_r) begin
      acc_nxt = acc_r + rd_q;
    end

    unique case (state_r)
      S_RUN: begin
        if (item_vld) begin
          item_pop = 1'b1;
          pos_nxt  = pos_eff;
          if (item.has_byte) begin
            rd_en     = 1'b1;
            rmw_issue = 1'b1;
            pos_nxt   = pos_wrap;
          end
          if (item.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pos_r == '0) begin
          state_nxt = S_FOLD;
          j_nxt     = '0;
        end else begin
          rd_en     = 1'b1;
          rmw_issue = 1'b1;
          rmw_add   = pad_val;
          pos_nxt   = pos_wrap;
        end
      end
      S_FOLD: begin
        rd_en   = 1'b1;
        rd_addr = j_r[AW-1:0];
        fold_rd = 1'b1;
        j_nxt   = CW'(j_r + CW'(1));
        if (j_r[1:0] == 2'b11) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load = 1'b1;
          acc_nxt  = '0;
          if (done) begin
            clr_all   = 1'b1;
            pos_nxt   = '0;
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_FOLD;
          end
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  // State, control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_RUN;
      pos_r      <= '0;
      j_r        <= '0;
      acc_r      <= '0;
      col_vld_r  <= '0;
      fold_rd_r  <= 1'b0;
      b_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      out_byte_r <= '0;
      out_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      j_r       <= j_nxt;
      acc_r     <= acc_nxt;
      fold_rd_r <= fold_rd;
      b_vld_r   <= rmw_issue;
      if (clr_all) begin
        col_vld_r <= '0;
      end else if (b_vld_r) begin
        col_vld_r[b_addr_r] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r  <= 1'b1;
        out_byte_r <= acc_r;
        out_last_r <= done;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q_r <= col_vld_r[rd_addr];
    end
    if (rmw_issue) begin
      b_addr_r <= rd_addr;
      b_add_r  <= rmw_add;
    end
  end

  // Column sum store
  csbd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_COLUMNS)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (b_vld_r),
    .wr_addr (b_addr_r),
    .wr_data (8'(rd_q + b_add_r)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign out_ch.valid       = out_vld_r;
  assign out_ch.digest_byte = out_byte_r;
  assign out_ch.digest_last = out_last_r;

  // Checks
  `CSBD_ASSERT_NOW(a_no_rw_collide, b_vld_r && rd_en, b_addr_r != rd_addr, "read hits write")
  `CSBD_ASSERT_NOW(a_fold_drained, state_r == S_FOLD, !b_vld_r, "fold started with write pending")
  `CSBD_ASSERT_NOW(a_pos_in_row, state_r != S_RUN, CW'(pos_r) < n_w, "column position past row")
  `CSBD_ASSERT_NEXT(a_clear_on_last, out_load && done, col_vld_r == '0 && pos_r == '0, "not cleared")

endmodule

>>> rtl/column_sum_byte_digest.sv
// ---------------------------------------------------------------------------
// column_sum_byte_digest
// Column-sum byte digest with a one-register row width setting.
// ---------------------------------------------------------------------------
// Message bytes are summed modulo 256 into n columns, n being row_width
// clamped to [16, MAX_COLUMNS] and rounded down to a multiple of four. A
// word with end_of_message set pads the rest of a partly filled row with n
// and then returns n/4 digest words, each the sum of four neighboring
// columns, the final one with digest_last set; the column state is then
// cleared for the next message. Words with neither a byte nor an end are
// dropped. Outside padding and fold, bytes are taken at one per cycle, set
// by the single column RAM read-modify-write pipeline. At message end each
// padded column gets one read-modify-write, and each digest word four
// column reads on the one RAM read port, a sum and an output load. A
// four-word queue in front takes words until full. Per-column valid bits
// clear the columns, so no clearing pass follows reset or a message. The
// user must write row_width only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
module column_sum_byte_digest #(
  parameter int MAX_COLUMNS = csbd_pkg::DEF_MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csbd_in_if.sink                    in_ch,
  csbd_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [csbd_pkg::CFG_W-1:0] cfg_wr_data
);

  logic [csbd_pkg::CFG_W-1:0] row_width_r;
  csbd_pkg::item_t            item;
  logic                       item_vld;
  logic                       item_pop;

  // Row width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= csbd_pkg::CFG_W'(csbd_pkg::ROW_WIDTH_RST);
    end else if (cfg_wr_en) begin
      row_width_r <= cfg_wr_data;
    end
  end

  csbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .item     (item),
    .item_vld (item_vld),
    .item_pop (item_pop)
  );

  csbd_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_width (row_width_r),
    .item      (item),
    .item_vld  (item_vld),
    .item_pop  (item_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/sv/tb_column_sum_byte_digest.sv
// ---------------------------------------------------------------------------
// tb_column_sum_byte_digest
// Self-checking testbench of the column-sum byte digest.
// ---------------------------------------------------------------------------
// Message words go in on a valid/ready channel and digest words come out on
// another, both with random gaps and burst stretches. A behavioral copy of
// the column sums predicts the digest words not typed in the table. A short
// table of directed words covers reset, the width extremes, clamping and
// rounding, empty messages, full rows, byte-with-end, dropped words and
// width changes in mid-message. Random messages follow, mostly well formed,
// with random row widths written between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_column_sum_byte_digest;

  localparam int RANDOM_WORDS   = 45;
  localparam int IDLE_SETTLE    = 32;
  localparam int WATCHDOG_LIMIT = 3000;

  // One digest word as the block returns it
  typedef struct {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_word_t;

  // Directed stimulus row; typed rows carry their digest words inline
  typedef struct packed {
    logic       set_w;
    logic [6:0] width;
    logic [7:0] data;
    logic       has;
    logic       eom;
    logic [7:0] rep;
    logic       typed;
    logic [4:0] tcount;
    logic [7:0] tbyte;
  } dir_row_t;

  localparam dir_row_t DIRECTED [18] = '{
    // empty message right after reset: four zero words
    '{1'b0, 7'd0,   8'h00, 1'b0, 1'b1, 8'd1,  1'b1, 5'd4,  8'h00},
    // word with neither byte nor end is dropped
    '{1'b0, 7'd0,   8'h00, 1'b0, 1'b0, 8'd1,  1'b0, 5'd0,  8'h00},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b0, 8'd1,  1'b0, 5'd0,  8'h00},
    '{1'b0, 7'd0,   8'h00, 1'b1, 1'b0, 8'd1,  1'b0, 5'd0,  8'h00},
    // byte and end in the same word
    '{1'b0, 7'd0,   8'h80, 1'b1, 1'b1, 8'd1,  1'b0, 5'd0,  8'h00},
    // width below range clamps to 16
    '{1'b1, 7'd0,   8'h00, 1'b0, 1'b1, 8'd1,  1'b1, 5'd4,  8'h00},
    // width above range clamps to 64
    '{1'b1, 7'd127, 8'h00, 1'b0, 1'b1, 8'd1,  1'b1, 5'd16, 8'h00},
    // exactly one full row of 0xFF, no padding
    '{1'b1, 7'd16,  8'hFF, 1'b1, 1'b0, 8'd15, 1'b0, 5'd0,  8'h00},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b1, 8'd1,  1'b1, 5'd4,  8'hFC},
    // narrow the row below the current column in mid-message
    '{1'b1, 7'd20,  8'h5A, 1'b1, 1'b0, 8'd17, 1'b0, 5'd0,  8'h00},
    '{1'b1, 7'd16,  8'h02, 1'b1, 1'b1, 8'd1,  1'b0, 5'd0,  8'h00},
    // 18 rounds down to 16; end-only word pads a partial row
    '{1'b1, 7'd18,  8'h7F, 1'b1, 1'b0, 8'd5,  1'b0, 5'd0,  8'h00},
    '{1'b0, 7'd0,   8'h00, 1'b0, 1'b1, 8'd1,  1'b0, 5'd0,  8'h00},
    // 63 rounds down to 60
    '{1'b1, 7'd63,  8'hAA, 1'b1, 1'b0, 8'd3,  1'b0, 5'd0,  8'h00},
    '{1'b0, 7'd0,   8'h55, 1'b1, 1'b1, 8'd1,  1'b0, 5'd0,  8'h00},
    // mid-message width change that keeps the current column
    '{1'b1, 7'd64,  8'h01, 1'b1, 1'b0, 8'd2,  1'b0, 5'd0,  8'h00},
    '{1'b1, 7'd32,  8'h03, 1'b1, 1'b1, 8'd1,  1'b0, 5'd0,  8'h00},
    // empty message at width 20: five zero words
    '{1'b1, 7'd20,  8'h00, 1'b0, 1'b1, 8'd1,  1'b1, 5'd5,  8'h00}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [csbd_pkg::CFG_W-1:0]     cfg_wr_data;

  csbd_in_if  in_if ();
  csbd_out_if out_if ();

  column_sum_byte_digest DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predictor state
  logic [7:0]                 col_sum [csbd_pkg::DEF_MAX_COLUMNS];
  int                         col_pos;
  logic [csbd_pkg::CFG_W-1:0] width_reg;
  logic                       msg_open;
  digest_word_t               expected_digests [$];

  // Run bookkeeping
  int  errors;
  int  words_sent;
  int  messages_sent;
  int  digests_checked;
  int  width_writes;
  int  mid_changes;
  int  min_cols;
  int  max_cols;
  bit  in_burst;
  bit  out_burst;

  // 8 time unit clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Effective column count for a row width setting
  function automatic int eff_cols(input logic [csbd_pkg::CFG_W-1:0] w);
    int n;
    n = int'(w);
    if (n < csbd_pkg::MIN_WIDTH) n = csbd_pkg::MIN_WIDTH;
    if (n > csbd_pkg::DEF_MAX_COLUMNS) n = csbd_pkg::DEF_MAX_COLUMNS;
    return n & ~3;
  endfunction

  // Append one predicted digest word
  task automatic add_expected(input digest_word_t w);
    expected_digests.insert(expected_digests.size(), w);
  endtask

  // Fold one message word into the column sums; at end, queue the digest if push is set
  task automatic digest_step(input logic [7:0] d, input logic h, input logic e,
                             input bit push);
    int         n;
    int         j;
    int         k;
    logic [7:0] s;
    digest_word_t w;
    n = eff_cols(width_reg);
    if (col_pos >= n) col_pos = 0;
    if (h) begin
      col_sum[col_pos] = col_sum[col_pos] + d;
      col_pos++;
      if (col_pos >= n) col_pos = 0;
      msg_open = 1'b1;
    end
    if (!e) return;
    if (col_pos != 0) begin
      for (j = col_pos; j < n; j++) col_sum[j] = col_sum[j] + n[7:0];
    end
    for (k = 0; k < n / 4; k++) begin
      s = col_sum[4*k] + col_sum[4*k+1] + col_sum[4*k+2] + col_sum[4*k+3];
      w.digest_byte = s;
      w.digest_last = (k + 1 == n / 4);
      if (push) add_expected(w);
    end
    for (j = 0; j < csbd_pkg::DEF_MAX_COLUMNS; j++) col_sum[j] = 8'h00;
    col_pos = 0;
    msg_open = 1'b0;
    messages_sent++;
  endtask

  // Sender gap: mostly none or short, now and then long
  function automatic int draw_gap();
    int r;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Byte values with a bias toward the extremes
  function automatic logic [7:0] draw_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Row width settings, extremes and out-of-range values included
  function automatic logic [csbd_pkg::CFG_W-1:0] draw_width();
    case ($urandom_range(0, 9))
      0: return 7'($urandom_range(0, 15));
      1: return 7'($urandom_range(65, 127));
      2: return 7'd16;
      3: return 7'd64;
      4: return 7'd127;
      5: return 7'd0;
      default: return 7'($urandom_range(16, 64));
    endcase
  endfunction

  // Send one word; called and returns at a falling edge
  task automatic send_word(input logic [7:0] d, input logic h, input logic e,
                           input logic typed, input int tcount,
                           input logic [7:0] tbyte);
    int           gap;
    int           i;
    digest_word_t w;
    in_if.data_byte      = d;
    in_if.has_byte       = h;
    in_if.end_of_message = e;
    in_if.valid          = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    digest_step(d, h, e, !typed);
    if (typed) begin
      for (i = 0; i < tcount; i++) begin
        w.digest_byte = tbyte;
        w.digest_last = (i + 1 == tcount);
        add_expected(w);
      end
    end
    words_sent++;
    @(negedge clk);
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every digest word is back and the pipeline has settled
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (expected_digests.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  // Write the row width register while the block is idle
  task automatic set_row_width(input logic [csbd_pkg::CFG_W-1:0] v);
    wait_idle();
    if (msg_open) mid_changes++;
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(posedge clk);
    width_reg = v;
    width_writes++;
    if (eff_cols(v) < min_cols) min_cols = eff_cols(v);
    if (eff_cols(v) > max_cols) max_cols = eff_cols(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Receiver: random stalls, with stretches of constant ready
  initial begin : drive_ready
    int stall;
    int phase_left;
    int r;
    stall        = 0;
    phase_left   = 0;
    out_if.ready = 1'b0;
    out_burst    = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        out_burst  = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!out_burst) begin
          if (r < 30) stall = $urandom_range(1, 3);
          else if (r < 36) stall = $urandom_range(4, 12);
          else if (r < 38) stall = $urandom_range(20, 40);
        end
      end
    end
  end

  // Compare each digest word with the oldest prediction
  always @(posedge clk) begin : check_digest
    digest_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_digests.size() == 0) begin
        $error("unexpected digest word: digest_byte %0h digest_last %0b",
               out_if.digest_byte, out_if.digest_last);
        errors++;
      end else begin
        want = expected_digests.pop_front();
        if (out_if.digest_byte !== want.digest_byte) begin
          $error("digest_byte: expected %0h, actual %0h",
                 want.digest_byte, out_if.digest_byte);
          errors++;
        end
        if (out_if.digest_last !== want.digest_last) begin
          $error("digest_last: expected %0b, actual %0b",
                 want.digest_last, out_if.digest_last);
          errors++;
        end
        digests_checked++;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    dir_row_t row;
    int       rand_words;
    int       n;
    int       len;
    int       body;
    int       r;
    int       i;
    bit       end_with_byte;
    bit       first_msg;

    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_if.valid          = 1'b0;
    in_if.data_byte      = 8'h00;
    in_if.has_byte       = 1'b0;
    in_if.end_of_message = 1'b0;
    for (i = 0; i < csbd_pkg::DEF_MAX_COLUMNS; i++) col_sum[i] = 8'h00;
    col_pos         = 0;
    width_reg       = csbd_pkg::CFG_W'(csbd_pkg::ROW_WIDTH_RST);
    msg_open        = 1'b0;
    errors          = 0;
    words_sent      = 0;
    messages_sent   = 0;
    digests_checked = 0;
    width_writes    = 0;
    mid_changes     = 0;
    min_cols        = eff_cols(csbd_pkg::CFG_W'(csbd_pkg::ROW_WIDTH_RST));
    max_cols        = eff_cols(csbd_pkg::CFG_W'(csbd_pkg::ROW_WIDTH_RST));
    in_burst        = 1'b0;

    // Synchronous reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    for (int k = 0; k < $size(DIRECTED); k++) begin
      row = DIRECTED[k];
      if (row.set_w) set_row_width(row.width);
      repeat (row.rep)
        send_word(row.data, row.has, row.eom, row.typed, int'(row.tcount), row.tbyte);
    end

    // Random messages
    rand_words = 0;
    first_msg  = 1'b1;
    while (rand_words < RANDOM_WORDS) begin
      in_burst = ($urandom_range(0, 4) == 0);
      if (first_msg || $urandom_range(0, 3) == 0) set_row_width(draw_width());
      n = eff_cols(width_reg);
      r = $urandom_range(0, 99);
      if (r < 12) len = 0;
      else if (r < 30) len = (n <= 32) ? n : $urandom_range(1, 8);
      else if (r < 38) len = $urandom_range(n + 1, n + 8);
      else len = $urandom_range(1, 14);
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      body = end_with_byte ? len - 1 : len;
      for (i = 0; i < body; i++) begin
        // dropped words and rare mid-message width writes
        if ($urandom_range(0, 99) < 8)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 0, 8'h00);
        if ($urandom_range(0, 99) < 2) set_row_width(draw_width());
        send_word(draw_byte(), 1'b1, 1'b0, 1'b0, 0, 8'h00);
        rand_words++;
      end
      send_word(end_with_byte ? draw_byte() : 8'($urandom_range(0, 255)),
                end_with_byte, 1'b1, 1'b0, 0, 8'h00);
      rand_words++;
      // sender sometimes holds off until the digest has drained
      if (first_msg || $urandom_range(0, 3) == 0) wait_idle();
      first_msg = 1'b0;
    end

    // Drain and settle
    in_if.valid = 1'b0;
    while (expected_digests.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);

    $display("covered %0d message words in %0d messages, %0d digest words checked",
             words_sent, messages_sent, digests_checked);
    $display("%0d width writes, %0d to %0d columns, %0d in mid-message",
             width_writes, min_cols, max_cols, mid_changes);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> column_sum_byte_digest.f
+incdir+rtl
rtl/csbd_pkg.sv
rtl/csbd_ifs.sv
rtl/csbd_ram.sv
rtl/csbd_front.sv
rtl/csbd_back.sv
rtl/column_sum_byte_digest.sv
tb/sv/tb_column_sum_byte_digest.sv
